// ===== hw/rtl/tga_rle_pixel_decoder_top_defines.svh =====
// Assertion macros used by the TGA RLE decoder checker.
`ifndef TGA_RLE_PIXEL_DECODER_TOP_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRD_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("trd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TRD_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("trd assertion failed");

`endif

// ===== hw/rtl/trd_pkg.sv =====
// Types, constants and pixel helpers for the TGA RLE pixel decoder.
package trd_pkg;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} trd_state_t;

	localparam logic REG_DEPTH_MODE  = 1'b0;
	localparam logic REG_PIXEL_TOTAL = 1'b1;

	localparam logic [1:0] DEPTH_8  = 2'd0;
	localparam logic [1:0] DEPTH_16 = 2'd1;
	localparam logic [1:0] DEPTH_24 = 2'd2;
	localparam logic [1:0] DEPTH_32 = 2'd3;

	localparam logic [7:0] RUN_FLAG   = 8'h80;
	localparam logic [7:0] COUNT_MASK = 8'h7F;
	localparam logic [4:0] FIELD_MASK = 5'h1F;

	localparam int CFG_DATA_W = 24;

	typedef struct packed {
		logic take_byte;
		logic emit_step;
	} trd_cmd_t;

	typedef struct packed {
		logic pix_complete;
		logic last_result;
	} trd_status_t;

	function automatic logic [2:0] bytes_per_pixel(logic [1:0] mode);
		logic [2:0] n;
		case (mode)
			DEPTH_8:  n = 3'd1;
			DEPTH_16: n = 3'd2;
			DEPTH_24: n = 3'd3;
			default:  n = 3'd4;
		endcase
		return n;
	endfunction

	// In 16-bit mode, 5-5-5 expands to three bytes, each field shifted left by 3; other depths pass through.
	function automatic logic [31:0] convert_pixel(logic [1:0] mode, logic [31:0] raw);
		logic [31:0] p;
		if (mode == DEPTH_16) begin
			p = {8'h00,
				raw[14:10] & FIELD_MASK, 3'b000,
				raw[9:5] & FIELD_MASK, 3'b000,
				raw[4:0] & FIELD_MASK, 3'b000};
		end else begin
			p = raw;
		end
		return p;
	endfunction

endpackage

// ===== hw/rtl/trd_ctrl.sv =====
// Controller FSM for the TGA RLE pixel decoder: byte intake and result emission.
module trd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  trd_pkg::trd_status_t status,
	output trd_pkg::trd_cmd_t    ctl
);
	import trd_pkg::*;

	trd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		ctl.take_byte = 1'b0;
		ctl.emit_step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				ctl.take_byte = in_valid;
				if (in_valid && status.pix_complete) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid     = 1'b1;
				ctl.emit_step = out_ready;
				if (out_ready && status.last_result) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/trd_datapath.sv =====
// Datapath for the TGA RLE pixel decoder: config, packet state, pixel assembly, counts.
module trd_datapath #(
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_addr,
	input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          cmd,
	input  logic [7:0]                    byte_in,
	input  trd_pkg::trd_cmd_t             ctl,
	output trd_pkg::trd_status_t          status,
	output logic [31:0]                   pixel_a,
	output logic [31:0]                   pixel_b,
	output logic                          pair_valid,
	output logic                          run_last,
	output logic                          image_done
);
	import trd_pkg::*;

	localparam int CW = PIXEL_COUNT_BITS;
	localparam int LW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

	logic [1:0]            depth_q;
	logic [CFG_DATA_W-1:0] total_q;
	logic                  expect_hdr_q;
	logic                  is_run_q;
	logic [7:0]            left_q;
	logic [1:0]            slot_q;
	logic [31:0]           hold_q;
	logic [CW-1:0]         written_q;
	logic                  complete_q;
	logic [31:0]           pix_q;
	logic [7:0]            remain_q;

	logic [LW-1:0] total_ext;
	logic [LW-1:0] max_ext;
	logic [CW-1:0] limit;
	logic [CW-1:0] room;
	logic          done_now;
	logic [31:0]   hold_next;
	logic [2:0]    slot_inc;
	logic          slot_full;
	logic [7:0]    emit_src;
	logic [7:0]    emit_cnt;
	logic [7:0]    left_next;
	logic          pair;
	logic [CW-1:0] written_next;

	// Effective total saturates at what the counter can hold.
	assign total_ext = LW'(total_q);
	assign max_ext   = LW'({CW{1'b1}});
	assign limit     = (total_ext > max_ext) ? CW'(max_ext) : CW'(total_ext);
	assign room      = limit - written_q;
	assign done_now  = complete_q || (written_q >= limit);

	assign hold_next = hold_q | ({24'h000000, byte_in} << {slot_q, 3'b000});
	assign slot_inc  = {1'b0, slot_q} + 3'd1;
	assign slot_full = (slot_inc >= bytes_per_pixel(depth_q));

	assign emit_src  = is_run_q ? left_q : 8'd1;
	assign emit_cnt  = (CW'(emit_src) > room) ? room[7:0] : emit_src;
	assign left_next = is_run_q ? 8'd0 : left_q - 8'd1;

	assign pair         = (remain_q >= 8'd2);
	assign written_next = written_q + (pair ? CW'(2) : CW'(1));

	assign status.pix_complete = !cmd && !done_now && !expect_hdr_q && slot_full;
	assign status.last_result  = (remain_q <= 8'd2);

	assign pixel_a    = pix_q;
	assign pixel_b    = pair ? pix_q : 32'h0;
	assign pair_valid = pair;
	assign run_last   = (remain_q <= 8'd2);
	assign image_done = (written_next >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= DEPTH_24;
			total_q      <= '0;
			expect_hdr_q <= 1'b1;
			is_run_q     <= 1'b0;
			left_q       <= '0;
			slot_q       <= '0;
			hold_q       <= '0;
			written_q    <= '0;
			complete_q   <= 1'b0;
			remain_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_DEPTH_MODE:  depth_q <= cfg_wdata[1:0];
					REG_PIXEL_TOTAL: total_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (ctl.take_byte) begin
				if (cmd) begin
					expect_hdr_q <= 1'b1;
					is_run_q     <= 1'b0;
					left_q       <= '0;
					slot_q       <= '0;
					hold_q       <= '0;
					written_q    <= '0;
					complete_q   <= 1'b0;
				end else if (done_now) begin
					complete_q <= 1'b1;
				end else if (expect_hdr_q) begin
					is_run_q     <= ((byte_in & RUN_FLAG) != 8'h00);
					left_q       <= (byte_in & COUNT_MASK) + 8'd1;
					slot_q       <= '0;
					hold_q       <= '0;
					expect_hdr_q <= 1'b0;
				end else if (!slot_full) begin
					hold_q <= hold_next;
					slot_q <= slot_inc[1:0];
				end else begin
					slot_q       <= '0;
					hold_q       <= '0;
					remain_q     <= emit_cnt;
					left_q       <= left_next;
					expect_hdr_q <= (left_next == 8'd0);
				end
			end
			if (ctl.emit_step) begin
				written_q <= written_next;
				remain_q  <= remain_q - (pair ? 8'd2 : 8'd1);
				if (written_next >= limit) begin
					complete_q <= 1'b1;
				end
			end
		end
	end

	// Finished pixel is payload only.
	always_ff @(posedge clk) begin
		if (ctl.take_byte && status.pix_complete) begin
			pix_q <= convert_pixel(depth_q, hold_next);
		end
	end

endmodule

// ===== hw/rtl/tga_rle_pixel_decoder_top.sv =====
// Top level of the TGA run-length-encoded pixel decoder.
//
// Usage:
//   cfg_we/cfg_addr/cfg_wdata write depth_mode (index 0) and pixel_total
//   (index 1); write only while the block is idle.
//   Input channel (in_valid/in_ready) carries one encoded byte per transfer,
//   or a restart command (cmd = 1) that clears the stream state.
//   Output channel (out_valid/out_ready) carries up to two decoded pixels per
//   transfer, with run_last on the last result of a byte and image_done on
//   the result that reaches the pixel total.
// Byte handling:
//   Header bytes, partial pixel bytes, restarts and ignored bytes give no
//   result and leave the block ready for the next byte. A byte that completes
//   a pixel moves the controller into its emission state for ceil(n/2)
//   output transfers, n being the pixels it yields (1 for a literal, up to
//   128 for a run). in_ready is low during that drain, so no new byte is
//   taken until the last result of the byte has been accepted.
// Reset: arst_n clears stream state at once; depth_mode goes to 24-bit and
//   pixel_total to 0, so the first stream byte after reset marks done.
// Stall: while out_ready is low the current result holds and no byte is taken.
// After the pixel total is reached, stream bytes are absorbed until restart.
module tga_rle_pixel_decoder_top #(
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_addr,
	input  logic [trd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           cmd,
	input  logic [7:0]                     byte_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    pixel_a,
	output logic [31:0]                    pixel_b,
	output logic                           pair_valid,
	output logic                           run_last,
	output logic                           image_done
);
	import trd_pkg::*;

	trd_cmd_t    ctl;
	trd_status_t status;

	// Controller: owns both handshakes, issues byte-take and emit-step commands.
	trd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.ctl       (ctl)
	);

	// Datapath: config registers, packet parser, pixel assembly and counters.
	trd_datapath #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.cmd        (cmd),
		.byte_in    (byte_in),
		.ctl        (ctl),
		.status     (status),
		.pixel_a    (pixel_a),
		.pixel_b    (pixel_b),
		.pair_valid (pair_valid),
		.run_last   (run_last),
		.image_done (image_done)
	);

endmodule

// ===== hw/rtl/trd_checker.sv =====
// Port-level assertion checker for the TGA RLE pixel decoder, bound to the top.
`include "tga_rle_pixel_decoder_top_defines.svh"

module trd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pixel_a,
	input logic [31:0] pixel_b,
	input logic        pair_valid,
	input logic        run_last,
	input logic        image_done
);

	// No byte is taken while results are pending.
	`TRD_ASSERT_IMP(a_no_intake_while_emit, clk, arst_n, out_valid, !in_ready)

	// A stalled result holds its pixel.
	`TRD_ASSERT_NXT(a_stall_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(pixel_a))

	// A result that is not the last of its byte is followed by another.
	`TRD_ASSERT_NXT(a_run_continues, clk, arst_n, out_valid && out_ready && !run_last,
		out_valid)

	// Reaching the total always ends the emission of the byte.
	`TRD_ASSERT_IMP(a_done_is_last, clk, arst_n, out_valid && image_done, run_last)

	// Second pixel is zero when not paired.
	`TRD_ASSERT_IMP(a_single_zero, clk, arst_n, out_valid && !pair_valid,
		pixel_b == 32'h0)

endmodule

bind tga_rle_pixel_decoder_top trd_checker u_trd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.pixel_a    (pixel_a),
	.pixel_b    (pixel_b),
	.pair_valid (pair_valid),
	.run_last   (run_last),
	.image_done (image_done)
);
